FILE: rtl/htc_pkg.sv
// ----------------------------------------------------------------------------
// htc_pkg
// shared types, constants and helper functions of the triangle clipper
// ----------------------------------------------------------------------------
package htc_pkg;

	localparam int NUM_PLANES = 7;
	localparam int WEIGHT_ONE = 65536;

	// plane codes, in clipping order
	localparam logic [2:0] PL_W     = 3'd0;
	localparam logic [2:0] PL_POS_X = 3'd1;
	localparam logic [2:0] PL_NEG_X = 3'd2;
	localparam logic [2:0] PL_POS_Y = 3'd3;
	localparam logic [2:0] PL_NEG_Y = 3'd4;
	localparam logic [2:0] PL_POS_Z = 3'd5;
	localparam logic [2:0] PL_NEG_Z = 3'd6;

	// component codes of one vertex
	localparam logic [2:0] CP_X  = 3'd0;
	localparam logic [2:0] CP_Y  = 3'd1;
	localparam logic [2:0] CP_Z  = 3'd2;
	localparam logic [2:0] CP_W  = 3'd3;
	localparam logic [2:0] CP_B0 = 3'd4;
	localparam logic [2:0] CP_B1 = 3'd5;
	localparam logic [2:0] CP_B2 = 3'd6;

	typedef struct packed {
		logic [16:0]        b2;
		logic [16:0]        b1;
		logic [16:0]        b0;
		logic signed [31:0] w;
		logic signed [31:0] z;
		logic signed [31:0] y;
		logic signed [31:0] x;
	} vtx_t;

	localparam int VTX_W = $bits(vtx_t);

	typedef enum logic [1:0] {
		WS_IN,
		WS_CUR,
		WS_MID
	} wsel_t;

	typedef enum logic [15:0] {
		S_COLLECT = 16'h0001,
		S_RD0     = 16'h0002,
		S_LD0     = 16'h0004,
		S_RDN     = 16'h0008,
		S_LDN     = 16'h0010,
		S_EMIT    = 16'h0020,
		S_DIV     = 16'h0040,
		S_MUL     = 16'h0080,
		S_ADD     = 16'h0100,
		S_PUTM    = 16'h0200,
		S_ADV     = 16'h0400,
		S_REJ     = 16'h0800,
		S_ORD     = 16'h1000,
		S_OLD     = 16'h2000,
		S_OHOLD   = 16'h4000,
		S_SPARE   = 16'h8000
	} state_t;

	typedef struct packed {
		logic        ram_we;
		wsel_t       wsel;
		logic [1:0]  arrival;
		logic        ld_cur;
		logic        ld_nxt;
		logic        advance;
		logic        div_init;
		logic        div_step;
		logic        mul;
		logic        add;
		logic [2:0]  comp;
		logic [2:0]  plane;
		logic        out_load;
		logic        out_rej;
		logic        out_last;
		logic [3:0]  out_total;
	} cmd_t;

	typedef struct packed {
		logic dc_neg;
		logic dn_neg;
	} sts_t;

	// signed distance of a vertex from a clip plane, exact in 33 bits
	function automatic logic signed [32:0] plane_dist(vtx_t v, logic [2:0] pl);
		logic signed [32:0] x, y, z, w, d;
		x = {v.x[31], v.x};
		y = {v.y[31], v.y};
		z = {v.z[31], v.z};
		w = {v.w[31], v.w};
		case (pl)
			PL_W:     d = w;
			PL_POS_X: d = w + x;
			PL_NEG_X: d = w - x;
			PL_POS_Y: d = w + y;
			PL_NEG_Y: d = w - y;
			PL_POS_Z: d = w + z;
			PL_NEG_Z: d = w - z;
			default:  d = '0;
		endcase
		return d;
	endfunction

	// one component widened to 33 bits signed
	function automatic logic signed [32:0] vtx_comp(vtx_t v, logic [2:0] k);
		logic signed [32:0] c;
		case (k)
			CP_X:    c = {v.x[31], v.x};
			CP_Y:    c = {v.y[31], v.y};
			CP_Z:    c = {v.z[31], v.z};
			CP_W:    c = {v.w[31], v.w};
			CP_B0:   c = {16'b0, v.b0};
			CP_B1:   c = {16'b0, v.b1};
			CP_B2:   c = {16'b0, v.b2};
			default: c = '0;
		endcase
		return c;
	endfunction

endpackage

FILE: rtl/htc_ram.sv
// ----------------------------------------------------------------------------
// htc_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module htc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/htc_dpath.sv
// ----------------------------------------------------------------------------
// htc_dpath
// vertex store, plane distances, crossing divider, interpolator, output word
// ----------------------------------------------------------------------------
module htc_dpath
	import htc_pkg::*;
#(
	parameter int MAX_OUT_VERTS = 10,
	parameter int FRAC_BITS     = 16,
	localparam int AW           = $clog2(2 * MAX_OUT_VERTS)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	input  logic [AW-1:0]      ram_waddr,
	input  logic [AW-1:0]      ram_raddr,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [31:0] pos_w,
	output sts_t               sts,
	output logic signed [31:0] clip_x,
	output logic signed [31:0] clip_y,
	output logic signed [31:0] clip_z,
	output logic signed [31:0] clip_w,
	output logic [16:0]        weight_first,
	output logic [16:0]        weight_second,
	output logic [16:0]        weight_third,
	output logic [3:0]         vertex_total,
	output logic               rejected,
	output logic               last_vertex
);

	localparam int PW = 35 + FRAC_BITS;
	localparam logic signed [PW-1:0] C_MAX  = PW'(33'sh0_7FFF_FFFF);
	localparam logic signed [PW-1:0] C_MIN  = -PW'(64'sh8000_0000);
	localparam logic signed [PW-1:0] W_ONE  = PW'(WEIGHT_ONE);
	localparam logic signed [PW-1:0] C_HALF = PW'(1) <<< (FRAC_BITS - 1);

	vtx_t               in_vtx, wdata, rdata;
	vtx_t               cur_q, nxt_q, mid_q;
	logic signed [32:0] dc_q, dn_q, rd_dist;
	logic [32:0]        a0, a1;
	logic [33:0]        den_q;
	logic [34:0]        rem_q;
	logic [FRAC_BITS:0] t_q;
	logic               rem_ge;
	logic signed [32:0] ca, cb;
	logic signed [PW-1:0] prod_s1, sum, res;

	// input vertex with unit weight for its arrival slot
	always_comb begin
		in_vtx.x  = pos_x;
		in_vtx.y  = pos_y;
		in_vtx.z  = pos_z;
		in_vtx.w  = pos_w;
		in_vtx.b0 = (cmd.arrival == 2'd0) ? 17'(WEIGHT_ONE) : '0;
		in_vtx.b1 = (cmd.arrival == 2'd1) ? 17'(WEIGHT_ONE) : '0;
		in_vtx.b2 = (cmd.arrival == 2'd2) ? 17'(WEIGHT_ONE) : '0;
	end

	always_comb begin
		case (cmd.wsel)
			WS_IN:   wdata = in_vtx;
			WS_CUR:  wdata = cur_q;
			WS_MID:  wdata = mid_q;
			default: wdata = cur_q;
		endcase
	end

	htc_ram #(
		.WIDTH (VTX_W),
		.DEPTH (2 * MAX_OUT_VERTS)
	) u_store (
		.clk   (clk),
		.we    (cmd.ram_we),
		.waddr (ram_waddr),
		.wdata (wdata),
		.raddr (ram_raddr),
		.rdata (rdata)
	);

	assign rd_dist = plane_dist(rdata, cmd.plane);
	assign sts.dc_neg = dc_q[32];
	assign sts.dn_neg = dn_q[32];

	// edge endpoints and distances
	always_ff @(posedge clk) begin
		if (cmd.ld_cur) begin
			cur_q <= rdata;
			dc_q  <= rd_dist;
		end else if (cmd.advance) begin
			cur_q <= nxt_q;
			dc_q  <= dn_q;
		end
		if (cmd.ld_nxt) begin
			nxt_q <= rdata;
			dn_q  <= rd_dist;
		end
	end

	// restoring divider, one quotient bit a cycle
	assign a0 = dc_q[32] ? 33'(-dc_q) : 33'(dc_q);
	assign a1 = dn_q[32] ? 33'(-dn_q) : 33'(dn_q);
	assign rem_ge = (rem_q >= 35'(den_q));

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			den_q <= 34'(a0) + 34'(a1);
			rem_q <= 35'(a0);
			t_q   <= '0;
		end else if (cmd.div_step) begin
			t_q   <= {t_q[FRAC_BITS-1:0], rem_ge};
			rem_q <= (rem_ge ? (rem_q - 35'(den_q)) : rem_q) << 1;
		end
	end

	// interpolation, one component at a time: a multiply step, then an add step
	assign ca = vtx_comp(cur_q, cmd.comp);
	assign cb = vtx_comp(nxt_q, cmd.comp);

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_s1 <= PW'(cb - ca) * $signed({{(PW-FRAC_BITS-1){1'b0}}, t_q});
		end
	end

	assign sum = ((prod_s1 + C_HALF) >>> FRAC_BITS) + PW'(ca);

	always_comb begin
		if (cmd.comp <= CP_W) begin
			if (sum > C_MAX)      res = C_MAX;
			else if (sum < C_MIN) res = C_MIN;
			else                  res = sum;
		end else begin
			if (sum < 0)          res = '0;
			else if (sum > W_ONE) res = W_ONE;
			else                  res = sum;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.add) begin
			case (cmd.comp)
				CP_X:    mid_q.x  <= res[31:0];
				CP_Y:    mid_q.y  <= res[31:0];
				CP_Z:    mid_q.z  <= res[31:0];
				CP_W:    mid_q.w  <= res[31:0];
				CP_B0:   mid_q.b0 <= res[16:0];
				CP_B1:   mid_q.b1 <= res[16:0];
				CP_B2:   mid_q.b2 <= res[16:0];
				default: mid_q    <= mid_q;
			endcase
		end
	end

	// output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_x        <= '0;
			clip_y        <= '0;
			clip_z        <= '0;
			clip_w        <= '0;
			weight_first  <= '0;
			weight_second <= '0;
			weight_third  <= '0;
			vertex_total  <= '0;
			rejected      <= 1'b0;
			last_vertex   <= 1'b0;
		end else if (cmd.out_load) begin
			if (cmd.out_rej) begin
				clip_x        <= '0;
				clip_y        <= '0;
				clip_z        <= '0;
				clip_w        <= '0;
				weight_first  <= '0;
				weight_second <= '0;
				weight_third  <= '0;
			end else begin
				clip_x        <= rdata.x;
				clip_y        <= rdata.y;
				clip_z        <= rdata.z;
				clip_w        <= rdata.w;
				weight_first  <= rdata.b0;
				weight_second <= rdata.b1;
				weight_third  <= rdata.b2;
			end
			vertex_total <= cmd.out_total;
			rejected     <= cmd.out_rej;
			last_vertex  <= cmd.out_last;
		end
	end

endmodule

FILE: rtl/htc_ctrl.sv
// ----------------------------------------------------------------------------
// htc_ctrl
// sequencer for vertex collection, plane passes and polygon readout
// ----------------------------------------------------------------------------
module htc_ctrl
	import htc_pkg::*;
#(
	parameter int MAX_OUT_VERTS = 10,
	parameter int FRAC_BITS     = 16,
	localparam int AW           = $clog2(2 * MAX_OUT_VERTS),
	localparam int CW           = $clog2(MAX_OUT_VERTS + 1),
	localparam int SW           = $clog2(FRAC_BITS + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	input  sts_t          sts,
	output cmd_t          cmd,
	output logic [AW-1:0] ram_waddr,
	output logic [AW-1:0] ram_raddr
);

	state_t        state_q;
	logic [1:0]    arr_q;
	logic          src_q;
	logic [2:0]    plane_q;
	logic [CW-1:0] n_q, cnt_q, i_q, k_q, j;
	logic [SW-1:0] step_q;
	logic [2:0]    comp_q;
	logic          rej_q;
	logic [AW-1:0] src_base, dst_base;
	logic          cnt_room, crossing, emit_cur, pass_end, out_end;

	assign src_base = src_q ? AW'(MAX_OUT_VERTS) : '0;
	assign dst_base = src_q ? '0 : AW'(MAX_OUT_VERTS);
	assign j        = (i_q + CW'(1) == n_q) ? '0 : i_q + CW'(1);
	assign cnt_room = (cnt_q < CW'(MAX_OUT_VERTS));
	assign crossing = (sts.dc_neg != sts.dn_neg);
	assign emit_cur = !sts.dc_neg && cnt_room;
	assign pass_end = (i_q + CW'(1) == n_q);
	assign out_end  = (k_q + CW'(1) == n_q);

	assign in_stall  = (state_q != S_COLLECT);
	assign out_valid = (state_q == S_OHOLD);

	always_comb begin
		cmd           = '0;
		cmd.wsel      = WS_IN;
		cmd.arrival   = arr_q;
		cmd.comp      = comp_q;
		cmd.plane     = plane_q;
		cmd.out_total = n_q[3:0];
		cmd.out_rej   = rej_q;
		cmd.out_last  = rej_q || out_end;
		ram_waddr     = AW'(arr_q);
		ram_raddr     = src_base;
		case (state_q)
			S_COLLECT: cmd.ram_we = in_valid;
			S_RD0:     ram_raddr = src_base;
			S_LD0:     cmd.ld_cur = 1'b1;
			S_RDN:     ram_raddr = src_base + AW'(j);
			S_LDN:     cmd.ld_nxt = 1'b1;
			S_EMIT: begin
				cmd.ram_we   = emit_cur;
				cmd.wsel     = WS_CUR;
				ram_waddr    = dst_base + AW'(cnt_q);
				cmd.div_init = 1'b1;
			end
			S_DIV:     cmd.div_step = 1'b1;
			S_MUL:     cmd.mul = 1'b1;
			S_ADD:     cmd.add = 1'b1;
			S_PUTM: begin
				cmd.ram_we = cnt_room;
				cmd.wsel   = WS_MID;
				ram_waddr  = dst_base + AW'(cnt_q);
			end
			S_ADV:     cmd.advance = 1'b1;
			S_REJ:     cmd.out_load = 1'b1;
			S_ORD:     ram_raddr = src_base + AW'(k_q);
			S_OLD:     cmd.out_load = 1'b1;
			default:   cmd.ram_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_COLLECT;
			arr_q   <= '0;
			src_q   <= 1'b0;
			plane_q <= '0;
			n_q     <= '0;
			cnt_q   <= '0;
			i_q     <= '0;
			k_q     <= '0;
			step_q  <= '0;
			comp_q  <= '0;
			rej_q   <= 1'b0;
		end else begin
			case (state_q)
				S_COLLECT: begin
					if (in_valid) begin
						if (arr_q == 2'd2) begin
							arr_q   <= '0;
							src_q   <= 1'b0;
							plane_q <= PL_W;
							n_q     <= CW'(3);
							cnt_q   <= '0;
							i_q     <= '0;
							state_q <= S_RD0;
						end else begin
							arr_q <= arr_q + 2'd1;
						end
					end
				end
				S_RD0: state_q <= S_LD0;
				S_LD0: state_q <= S_RDN;
				S_RDN: state_q <= S_LDN;
				S_LDN: state_q <= S_EMIT;
				S_EMIT: begin
					if (emit_cur) cnt_q <= cnt_q + CW'(1);
					step_q  <= '0;
					state_q <= crossing ? S_DIV : S_ADV;
				end
				S_DIV: begin
					step_q <= step_q + SW'(1);
					if (step_q == SW'(FRAC_BITS)) begin
						comp_q  <= CP_X;
						state_q <= S_MUL;
					end
				end
				S_MUL: state_q <= S_ADD;
				S_ADD: begin
					if (comp_q == CP_B2) begin
						state_q <= S_PUTM;
					end else begin
						comp_q  <= comp_q + 3'd1;
						state_q <= S_MUL;
					end
				end
				S_PUTM: begin
					if (cnt_room) cnt_q <= cnt_q + CW'(1);
					state_q <= S_ADV;
				end
				S_ADV: begin
					if (pass_end) begin
						n_q     <= cnt_q;
						src_q   <= ~src_q;
						plane_q <= plane_q + 3'd1;
						cnt_q   <= '0;
						i_q     <= '0;
						k_q     <= '0;
						if (cnt_q < CW'(3)) begin
							rej_q   <= 1'b1;
							state_q <= S_REJ;
						end else if (plane_q == PL_NEG_Z) begin
							rej_q   <= 1'b0;
							state_q <= S_ORD;
						end else begin
							state_q <= S_RD0;
						end
					end else begin
						i_q     <= i_q + CW'(1);
						state_q <= S_RDN;
					end
				end
				S_REJ: state_q <= S_OHOLD;
				S_ORD: state_q <= S_OLD;
				S_OLD: state_q <= S_OHOLD;
				S_OHOLD: begin
					if (!out_stall) begin
						if (rej_q || out_end) begin
							state_q <= S_COLLECT;
						end else begin
							k_q     <= k_q + CW'(1);
							state_q <= S_ORD;
						end
					end
				end
				default: state_q <= S_COLLECT;
			endcase
		end
	end

endmodule

FILE: rtl/homogeneous_triangle_clipper_core.sv
// ----------------------------------------------------------------------------
// homogeneous_triangle_clipper_core
// clip-space triangle clipper against the seven homogeneous view planes
// ----------------------------------------------------------------------------
// Three vertex words (x, y, z, w in signed Q16.16) are taken one per handshake;
// after the third the triangle is clipped against w >= 0 and then +-x, +-y and
// +-z against w, in that order, and the resulting polygon is sent out one vertex
// word at a time with its barycentric weights and a last flag. If fewer than
// three vertices survive a plane, one rejected word is sent instead. Each plane
// pass reads the first vertex and then walks the polygon edges; an edge that
// crosses the plane also goes through a radix-2 divider for the crossing
// parameter, then seven components through one shared multiplier and a
// rounding/saturating adder. Readout reads each vertex word from the ram and
// holds it on the output until it is taken. All vertex traffic goes through
// one ping-pong vertex ram with a single write and a single registered read
// port, which is what serializes the pass.
// The block takes no new vertex word while a triangle is being clipped or read
// out.
// ----------------------------------------------------------------------------
module homogeneous_triangle_clipper_core
	import htc_pkg::*;
#(
	parameter int MAX_OUT_VERTS = 10,
	parameter int FRAC_BITS     = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	// vertex input channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [31:0] pos_w,
	// clipped vertex output channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] clip_x,
	output logic signed [31:0] clip_y,
	output logic signed [31:0] clip_z,
	output logic signed [31:0] clip_w,
	output logic [16:0]        weight_first,
	output logic [16:0]        weight_second,
	output logic [16:0]        weight_third,
	output logic [3:0]         vertex_total,
	output logic               rejected,
	output logic               last_vertex
);

	localparam int AW = $clog2(2 * MAX_OUT_VERTS);

	cmd_t          cmd;
	sts_t          sts;
	logic [AW-1:0] ram_waddr;
	logic [AW-1:0] ram_raddr;

	// sequencer: collection, plane passes, readout
	htc_ctrl #(
		.MAX_OUT_VERTS (MAX_OUT_VERTS),
		.FRAC_BITS     (FRAC_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd),
		.ram_waddr (ram_waddr),
		.ram_raddr (ram_raddr)
	);

	// vertex ram, distances, divider, interpolator and output word register
	htc_dpath #(
		.MAX_OUT_VERTS (MAX_OUT_VERTS),
		.FRAC_BITS     (FRAC_BITS)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.ram_waddr     (ram_waddr),
		.ram_raddr     (ram_raddr),
		.pos_x         (pos_x),
		.pos_y         (pos_y),
		.pos_z         (pos_z),
		.pos_w         (pos_w),
		.sts           (sts),
		.clip_x        (clip_x),
		.clip_y        (clip_y),
		.clip_z        (clip_z),
		.clip_w        (clip_w),
		.weight_first  (weight_first),
		.weight_second (weight_second),
		.weight_third  (weight_third),
		.vertex_total  (vertex_total),
		.rejected      (rejected),
		.last_vertex   (last_vertex)
	);

	// input and output never active together
	assert property (@(posedge clk) disable iff (!arst_n)
		!(out_valid && !in_stall))
		else $error("input open while a result word is pending");

	// a rejected word is the only and last word of its triangle
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && rejected) |-> (last_vertex && vertex_total < 4'd3))
		else $error("rejected word malformed");

	// a polygon word carries at least three vertices
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !rejected) |-> (vertex_total >= 4'd3 || MAX_OUT_VERTS > 15))
		else $error("polygon word with too few vertices");

	// weights stay within one
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (weight_first <= 17'd65536 && weight_second <= 17'd65536
			&& weight_third <= 17'd65536))
		else $error("weight out of range");

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the homogeneous triangle clipper
// ----------------------------------------------------------------------------
// Vertex words go in over the valid/stall input channel. A directed table is
// walked first, then random triangles follow. Most random triangles are built
// to straddle the view planes; the rest are raw 32-bit noise. Every accepted
// vertex feeds a local clip model. Each completed triangle pushes its clipped
// polygon, or its one rejected word, into a queue. The output monitor checks
// each accepted word against the head of that queue.
// ----------------------------------------------------------------------------
module tb
	import htc_pkg::*;
;

	localparam int    MAX_VERTS   = 10;
	localparam int    FRAC        = 16;
	localparam int    ONE         = 65536;
	localparam int    RAND_TRIS   = 147;
	localparam int    IDLE_LIMIT  = 40000;
	localparam longint COORD_MIN  = -64'sd2147483648;
	localparam longint COORD_MAX  = 64'sd2147483647;

	// component slots of one stored vertex
	localparam int K_X  = 0;
	localparam int K_W  = 3;
	localparam int K_B0 = 4;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic signed [31:0] w;
		logic [16:0]        b0;
		logic [16:0]        b1;
		logic [16:0]        b2;
		logic [3:0]         total;
		logic               rej;
		logic               last;
	} clip_word_t;

	// directed row: one vertex, plus a typed rejection on the closing vertex
	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic signed [31:0] w;
		logic               typed_rej;
		logic [3:0]         typed_total;
	} vtx_row_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic signed [31:0] pos_x, pos_y, pos_z, pos_w;
	logic               out_valid;
	logic               out_stall;
	logic signed [31:0] clip_x, clip_y, clip_z, clip_w;
	logic [16:0]        weight_first, weight_second, weight_third;
	logic [3:0]         vertex_total;
	logic               rejected;
	logic               last_vertex;

	homogeneous_triangle_clipper_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.pos_x         (pos_x),
		.pos_y         (pos_y),
		.pos_z         (pos_z),
		.pos_w         (pos_w),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.clip_x        (clip_x),
		.clip_y        (clip_y),
		.clip_z        (clip_z),
		.clip_w        (clip_w),
		.weight_first  (weight_first),
		.weight_second (weight_second),
		.weight_third  (weight_third),
		.vertex_total  (vertex_total),
		.rejected      (rejected),
		.last_vertex   (last_vertex)
	);

	// 12 ns clock
	initial clk = 1'b0;
	always #6 clk = ~clk;

	// ------------------------------------------------------------------
	// clip model: two banks of MAX_VERTS vertices, seven components each
	// ------------------------------------------------------------------
	longint     poly_bank [2*MAX_VERTS][7];
	int         arrivals;
	clip_word_t tri_words [MAX_VERTS];
	int         tri_count;
	clip_word_t expected_words[$];

	function automatic longint plane_distance(int idx, int pl);
		longint x, y, z, w;
		x = poly_bank[idx][0];
		y = poly_bank[idx][1];
		z = poly_bank[idx][2];
		w = poly_bank[idx][3];
		case (pl)
			PL_W:     return w;
			PL_POS_X: return w + x;
			PL_NEG_X: return w - x;
			PL_POS_Y: return w + y;
			PL_NEG_Y: return w - y;
			PL_POS_Z: return w + z;
			PL_NEG_Z: return w - z;
			default:  return 0;
		endcase
	endfunction

	function automatic longint clamp_to(longint v, longint lo, longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// a + (b - a) * t, rounded half up at FRAC fraction bits
	function automatic longint lerp_round(longint a, longint b, longint t);
		longint prod;
		prod = (b - a) * t;
		return a + ((prod + (64'sd1 <<< (FRAC - 1))) >>> FRAC);
	endfunction

	function automatic int clip_against_plane(int pl, int src, int dst, int n);
		int     cnt, i, j, k, cur_idx, nxt_idx, slot;
		longint dc, dn, a0, a1, den, t;
		cnt = 0;
		dc  = plane_distance(src * MAX_VERTS, pl);
		for (i = 0; i < n; i++) begin
			j       = (i + 1) % n;
			cur_idx = src * MAX_VERTS + i;
			nxt_idx = src * MAX_VERTS + j;
			dn      = plane_distance(nxt_idx, pl);
			// distance zero counts as inside
			if (dc >= 0 && cnt < MAX_VERTS) begin
				for (k = 0; k < 7; k++)
					poly_bank[dst * MAX_VERTS + cnt][k] = poly_bank[cur_idx][k];
				cnt++;
			end
			if ((dc >= 0) != (dn >= 0) && cnt < MAX_VERTS) begin
				a0  = (dc < 0) ? -dc : dc;
				a1  = (dn < 0) ? -dn : dn;
				den = a0 + a1;
				t   = (den != 0) ? (a0 <<< FRAC) / den : 0;
				if (t > ONE)
					t = ONE;
				slot = dst * MAX_VERTS + cnt;
				for (k = 0; k < 7; k++)
					poly_bank[slot][k] = clamp_to(
						lerp_round(poly_bank[cur_idx][k], poly_bank[nxt_idx][k], t),
						(k < K_B0) ? COORD_MIN : 0,
						(k < K_B0) ? COORD_MAX : ONE);
				cnt++;
			end
			dc = dn;
		end
		return cnt;
	endfunction

	// stores one vertex; on the third, clips and fills tri_words / tri_count
	function automatic void clip_triangle_step(logic signed [31:0] x, y, z, w);
		int n, src, pl, k, idx;
		tri_count = 0;
		poly_bank[arrivals][0] = x;
		poly_bank[arrivals][1] = y;
		poly_bank[arrivals][2] = z;
		poly_bank[arrivals][3] = w;
		for (k = 0; k < 3; k++)
			poly_bank[arrivals][K_B0 + k] = (k == arrivals) ? ONE : 0;
		arrivals++;
		if (arrivals < 3)
			return;
		arrivals = 0;
		n   = 3;
		src = 0;
		for (pl = 0; pl < NUM_PLANES && n >= 3; pl++) begin
			n   = clip_against_plane(pl, src, src ^ 1, n);
			src = src ^ 1;
		end
		if (n < 3) begin
			tri_words[0]       = '0;
			tri_words[0].total = n[3:0];
			tri_words[0].rej   = 1'b1;
			tri_words[0].last  = 1'b1;
			tri_count          = 1;
			return;
		end
		for (k = 0; k < n; k++) begin
			idx               = src * MAX_VERTS + k;
			tri_words[k].x    = poly_bank[idx][K_X][31:0];
			tri_words[k].y    = poly_bank[idx][1][31:0];
			tri_words[k].z    = poly_bank[idx][2][31:0];
			tri_words[k].w    = poly_bank[idx][K_W][31:0];
			tri_words[k].b0   = poly_bank[idx][4][16:0];
			tri_words[k].b1   = poly_bank[idx][5][16:0];
			tri_words[k].b2   = poly_bank[idx][6][16:0];
			tri_words[k].total = n[3:0];
			tri_words[k].rej  = 1'b0;
			tri_words[k].last = (k == n - 1);
		end
		tri_count = n;
	endfunction

	// ------------------------------------------------------------------
	// input driver: bursts of words with random gaps in between
	// ------------------------------------------------------------------
	int burst_left;
	int idle_cycles = 0;

	task automatic send_vertex(vtx_row_t row);
		int gap, k;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			// roughly a quarter of bursts start back to back
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
		end else begin
			gap = 0;
		end
		burst_left--;
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		pos_x    <= row.x;
		pos_y    <= row.y;
		pos_z    <= row.z;
		pos_w    <= row.w;
		// hold the word until it is taken
		do @(posedge clk); while (in_stall);
		clip_triangle_step(row.x, row.y, row.z, row.w);
		if (row.typed_rej && tri_count > 0) begin
			// closing vertex with a result read straight off the table
			tri_words[0]       = '0;
			tri_words[0].total = row.typed_total;
			tri_words[0].rej   = 1'b1;
			tri_words[0].last  = 1'b1;
			tri_count          = 1;
		end
		for (k = 0; k < tri_count; k++)
			expected_words.push_back(tri_words[k]);
	endtask

	// ------------------------------------------------------------------
	// output side: stall pattern switches between four modes, picked at random
	// ------------------------------------------------------------------
	int stall_mode;
	int stall_phase;

	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall   <= 1'b0;
			stall_mode  <= 0;
			stall_phase <= 0;
		end else begin
			stall_phase <= stall_phase + 1;
			if (stall_phase % 64 == 63)
				stall_mode <= $urandom_range(0, 3);
			case (stall_mode)
				0:       out_stall <= 1'b0;                          // free flowing
				1:       out_stall <= ($urandom_range(0, 3) == 0);   // light
				2:       out_stall <= ($urandom_range(0, 3) != 0);   // heavy
				default: out_stall <= (stall_phase % 5) < 2;         // periodic
			endcase
		end
	end

	// ------------------------------------------------------------------
	// result checker and watchdog
	// ------------------------------------------------------------------
	int         mismatch_count = 0;
	clip_word_t head_word;
	clip_word_t got_word;

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			got_word = {clip_x, clip_y, clip_z, clip_w, weight_first, weight_second,
				weight_third, vertex_total, rejected, last_vertex};
			if (expected_words.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected word: %p", got_word);
			end else begin
				head_word = expected_words.pop_front();
				if (got_word !== head_word) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: expected %p actual %p", head_word, got_word);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog expired");
			$display("FAILURE");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// directed table: triangles, three rows each
	// ------------------------------------------------------------------
	localparam vtx_row_t DIRECTED [21] = '{
		// fully inside
		'{32'sd0,      32'sd0,      32'sd0, 32'sd65536, 1'b0, 4'd0},
		'{32'sd32768,  32'sd0,      32'sd0, 32'sd65536, 1'b0, 4'd0},
		'{32'sd0,      32'sd32768,  32'sd0, 32'sd65536, 1'b0, 4'd0},
		// all behind the eye: rejected on the w plane with nothing left
		'{32'sd0,      32'sd0,      32'sd0, -32'sd65536, 1'b0, 4'd0},
		'{32'sd65536,  32'sd0,      32'sd0, -32'sd65536, 1'b0, 4'd0},
		'{32'sd0,      32'sd65536,  32'sd0, -32'sd65536, 1'b1, 4'd0},
		// all beyond +x: rejected on the -x + w plane with nothing left
		'{32'sd131072, 32'sd0,      32'sd0, 32'sd65536, 1'b0, 4'd0},
		'{32'sd196608, 32'sd0,      32'sd0, 32'sd65536, 1'b0, 4'd0},
		'{32'sd131072, 32'sd65536,  32'sd0, 32'sd65536, 1'b1, 4'd0},
		// straddles +x and +y
		'{32'sd0,      32'sd0,      32'sd0, 32'sd65536, 1'b0, 4'd0},
		'{32'sd196608, 32'sd0,      32'sd0, 32'sd65536, 1'b0, 4'd0},
		'{32'sd0,      32'sd196608, 32'sd0, 32'sd65536, 1'b0, 4'd0},
		// field extremes
		'{32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 1'b0, 4'd0},
		'{32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 1'b0, 4'd0},
		'{32'sd0,       32'sd0,       32'sd0,       32'h80000000, 1'b0, 4'd0},
		// every vertex on every plane
		'{32'sd0, 32'sd0, 32'sd0, 32'sd0, 1'b0, 4'd0},
		'{32'sd0, 32'sd0, 32'sd0, 32'sd0, 1'b0, 4'd0},
		'{32'sd0, 32'sd0, 32'sd0, 32'sd0, 1'b0, 4'd0},
		// crosses all planes, one vertex behind w
		'{-32'sd262144, -32'sd262144, -32'sd262144, 32'sd65536, 1'b0, 4'd0},
		'{32'sd262144,  -32'sd262144, 32'sd262144,  -32'sd65536, 1'b0, 4'd0},
		'{32'sd0,       32'sd262144,  32'sd0,       32'sd65536, 1'b0, 4'd0}
	};

	function automatic logic signed [31:0] near_coord(int w);
		int span;
		span = (w < 0) ? -w : w;
		return $signed($urandom_range(0, 6 * span)) - 3 * span;
	endfunction

	initial begin
		vtx_row_t row;
		int       i, v, w;
		bit       noisy;
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		pos_x          = '0;
		pos_y          = '0;
		pos_z          = '0;
		pos_w          = '0;
		arrivals       = 0;
		burst_left     = 0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		for (i = 0; i < 21; i++)
			send_vertex(DIRECTED[i]);

		// random triangles: mostly near the view volume, some raw noise
		for (i = 0; i < RAND_TRIS; i++) begin
			noisy = ($urandom_range(0, 6) == 0);
			for (v = 0; v < 3; v++) begin
				row = '0;
				if (noisy) begin
					row.x = $urandom;
					row.y = $urandom;
					row.z = $urandom;
					row.w = $urandom;
				end else begin
					w = $urandom_range(16384, 262144);
					if ($urandom_range(0, 7) == 0)
						w = -w;
					row.w = w;
					row.x = near_coord(w);
					row.y = near_coord(w);
					row.z = near_coord(w);
				end
				send_vertex(row);
			end
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);

		if (mismatch_count == 0 && expected_words.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
